// ===== sv/kvs_pkg.sv =====
// Shared types, constants and character helpers for the status string parser.
`default_nettype none

package kvs_pkg;

  localparam int KeyCount   = 6;
  localparam int TagCount   = 4;
  localparam int KeyTextLen = 9;
  localparam int TagTextLen = 11;

  typedef logic [KeyCount-1:0] key_set_t;
  typedef logic [TagCount-1:0] tag_set_t;
  typedef logic [3:0]          text_pos_t;

  localparam logic [31:0] NumStop    = 32'h7FFF_FFFF;
  localparam logic [31:0] PctMax     = 32'd100;
  localparam logic [7:0]  PctUnknown = 8'hFF;
  localparam logic [31:0] DecRadix   = 32'd10;
  localparam text_pos_t   PosMax     = 4'hF;

  // Key indexes, in table order
  localparam logic [2:0] KeyPresent   = 3'd0;
  localparam logic [2:0] KeyState     = 3'd1;
  localparam logic [2:0] KeyPercent   = 3'd2;
  localparam logic [2:0] KeyDesign    = 3'd3;
  localparam logic [2:0] KeyRemaining = 3'd4;
  localparam logic [2:0] KeyRate      = 3'd5;

  localparam logic [1:0] StateUnknown = 2'd0;

  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CaseBit   = 8'h20;

  // Left-justified keyword text, padded with blanks past the length
  localparam logic [KeyTextLen*8-1:0] KeyText [KeyCount] = '{
    "present  ", "state    ", "percent  ", "design   ", "remaining", "rate     "
  };
  localparam text_pos_t KeyLen [KeyCount] = '{4'd7, 4'd5, 4'd7, 4'd6, 4'd9, 4'd4};

  localparam logic [TagTextLen*8-1:0] TagText [TagCount] = '{
    "charging   ", "discharging", "full       ", "unknown    "
  };
  localparam text_pos_t  TagLen  [TagCount] = '{4'd8, 4'd11, 4'd4, 4'd7};
  localparam logic [1:0] TagCode [TagCount] = '{2'd1, 2'd2, 2'd3, 2'd0};

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } kvs_item_t;

  typedef struct packed {
    logic        recognized;
    logic        battery_present;
    logic [1:0]  charge_state;
    logic [7:0]  charge_percent;
    logic [31:0] design_capacity;
    logic [31:0] remaining_capacity;
    logic [31:0] present_rate;
  } kvs_rec_t;

  localparam kvs_rec_t RecReset = '{
    recognized:         1'b0,
    battery_present:    1'b1,
    charge_state:       StateUnknown,
    charge_percent:     PctUnknown,
    design_capacity:    32'd0,
    remaining_capacity: 32'd0,
    present_rate:       32'd0
  };

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= CharUpA && c <= CharUpZ) begin
      return c | CaseBit;
    end
    return c;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return c == CharComma || c == CharSemi || c == CharSpace ||
           c == CharTab || c == CharLf || c == CharCr;
  endfunction

  function automatic logic [7:0] key_char_at(input int k, input text_pos_t pos);
    int sh;
    sh = 0;
    if (pos < KeyLen[k]) begin
      sh = 8 * (KeyTextLen - 1 - int'(pos));
      return KeyText[k][sh +: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic [7:0] tag_char_at(input int t, input text_pos_t pos);
    int sh;
    sh = 0;
    if (pos < TagLen[t]) begin
      sh = 8 * (TagTextLen - 1 - int'(pos));
      return TagText[t][sh +: 8];
    end
    return 8'h00;
  endfunction

  function automatic text_pos_t pos_inc(input text_pos_t pos);
    return (pos == PosMax) ? pos : pos + 4'd1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kvs_if.sv =====
// Valid/ready channel interfaces for text bytes in and status records out.
`default_nettype none

interface kvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface kvs_out_if;
  logic        valid;
  logic        ready;
  logic        recognized;
  logic        battery_present;
  logic [1:0]  charge_state;
  logic [7:0]  charge_percent;
  logic [31:0] design_capacity;
  logic [31:0] remaining_capacity;
  logic [31:0] present_rate;

  modport source (output valid, output recognized, output battery_present,
                  output charge_state, output charge_percent, output design_capacity,
                  output remaining_capacity, output present_rate, input ready);
  modport sink   (input valid, input recognized, input battery_present,
                  input charge_state, input charge_percent, input design_capacity,
                  input remaining_capacity, input present_rate, output ready);
endinterface

`default_nettype wire

// ===== sv/kvs_in_reg.sv =====
// Input register: holds one accepted text byte until the parser consumes it.
`default_nettype none

module kvs_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  kvs_in_if.sink                 in_i,
  input  wire logic              take_i,
  output logic                   item_valid_o,
  output kvs_pkg::kvs_item_t     item_o
);

  logic               valid_q;
  kvs_pkg::kvs_item_t item_q;

  assign in_i.ready   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.text_byte  <= in_i.text_byte;
      item_q.final_byte <= in_i.final_byte;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kvs_core.sv =====
// Parser state: token phase, keyword and tag matching, decimal accumulate, record.
`default_nettype none

module kvs_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire kvs_pkg::kvs_item_t item_i,
  output logic                    emit_o,
  output kvs_pkg::kvs_rec_t       rec_o
);

  typedef enum logic [1:0] {
    PhSep   = 2'd0,
    PhKey   = 2'd1,
    PhValue = 2'd2
  } phase_e;

  phase_e                    phase_q, phase_d;
  kvs_pkg::text_pos_t        key_pos_q, key_pos_d, key_pos_b;
  kvs_pkg::key_set_t         key_cand_q, key_cand_d, key_cand_b;
  logic                      nonempty_q, nonempty_d;
  logic                      first_zero_q, first_zero_d;
  logic [31:0]               acc_q, acc_d, acc_n;
  logic                      stopped_q, stopped_d;
  kvs_pkg::text_pos_t        tag_pos_q, tag_pos_d;
  kvs_pkg::tag_set_t         tag_cand_q, tag_cand_d;
  kvs_pkg::kvs_rec_t         rec_q, rec_d, rec_c;

  logic [7:0] c, lc;
  logic       sep, eq, digit;
  logic       do_key, do_start, do_val, sep_commit, commit_en;
  logic [2:0] which;
  logic [1:0] tag;

  always_comb begin
    c     = item_i.text_byte;
    lc    = kvs_pkg::to_lower(c);
    sep   = kvs_pkg::is_sep(c);
    eq    = (c == kvs_pkg::CharEq);
    digit = (c >= kvs_pkg::CharZero) && (c <= kvs_pkg::CharNine);
    acc_n = acc_q * kvs_pkg::DecRadix + {24'd0, c - kvs_pkg::CharZero};

    phase_d      = phase_q;
    key_pos_d    = key_pos_q;
    key_cand_d   = key_cand_q;
    nonempty_d   = nonempty_q;
    first_zero_d = first_zero_q;
    acc_d        = acc_q;
    stopped_d    = stopped_q;
    tag_pos_d    = tag_pos_q;
    tag_cand_d   = tag_cand_q;
    key_pos_b    = key_pos_q;
    key_cand_b   = key_cand_q;
    do_key       = 1'b0;
    do_start     = 1'b0;
    do_val       = 1'b0;
    sep_commit   = 1'b0;
    which        = kvs_pkg::KeyPresent;
    tag          = kvs_pkg::StateUnknown;

    unique case (phase_q)
      PhKey: begin
        if (sep) begin
          phase_d = PhSep;
        end else if (eq) begin
          do_start = 1'b1;
        end else begin
          do_key = 1'b1;
        end
      end
      PhValue: begin
        if (sep) begin
          sep_commit = 1'b1;
          phase_d    = PhSep;
        end else begin
          do_val = 1'b1;
        end
      end
      default: begin
        // A non-separator opens a new token
        if (!sep) begin
          key_pos_b  = '0;
          key_cand_b = '1;
          if (eq) begin
            do_start = 1'b1;
          end else begin
            phase_d = PhKey;
            do_key  = 1'b1;
          end
        end
      end
    endcase

    if (do_key) begin
      for (int k = 0; k < kvs_pkg::KeyCount; k++) begin
        key_cand_d[k] = key_cand_b[k] && (key_pos_b < kvs_pkg::KeyLen[k]) &&
                        (kvs_pkg::key_char_at(k, key_pos_b) == lc);
      end
      key_pos_d = kvs_pkg::pos_inc(key_pos_b);
    end

    if (do_start) begin
      // Keep only keys whose length matches the text seen
      for (int k = 0; k < kvs_pkg::KeyCount; k++) begin
        key_cand_d[k] = key_cand_b[k] && (kvs_pkg::KeyLen[k] == key_pos_b);
      end
      key_pos_d    = key_pos_b;
      nonempty_d   = 1'b0;
      first_zero_d = 1'b0;
      acc_d        = '0;
      stopped_d    = 1'b0;
      tag_pos_d    = '0;
      tag_cand_d   = '1;
      phase_d      = PhValue;
    end

    if (do_val) begin
      nonempty_d   = 1'b1;
      first_zero_d = nonempty_q ? first_zero_q : (c == kvs_pkg::CharZero);
      if (!stopped_q) begin
        if (!digit) begin
          stopped_d = 1'b1;
        end else begin
          acc_d     = acc_n;
          stopped_d = (acc_n > kvs_pkg::NumStop);
        end
      end
      for (int t = 0; t < kvs_pkg::TagCount; t++) begin
        tag_cand_d[t] = tag_cand_q[t] && (tag_pos_q < kvs_pkg::TagLen[t]) &&
                        (kvs_pkg::tag_char_at(t, tag_pos_q) == lc);
      end
      tag_pos_d = kvs_pkg::pos_inc(tag_pos_q);
    end

    // Commit on a separator, or on a final byte that leaves a value open
    commit_en = sep_commit || (item_i.final_byte && phase_d == PhValue);

    for (int k = kvs_pkg::KeyCount - 1; k >= 0; k--) begin
      if (key_cand_d[k]) begin
        which = 3'(k);
      end
    end
    for (int t = 0; t < kvs_pkg::TagCount; t++) begin
      if (tag_cand_d[t] && tag_pos_d == kvs_pkg::TagLen[t]) begin
        tag = kvs_pkg::TagCode[t];
      end
    end

    rec_c = rec_q;
    if (commit_en && (|key_cand_d)) begin
      rec_c.recognized = 1'b1;
      unique case (which)
        kvs_pkg::KeyPresent:   rec_c.battery_present = nonempty_d && !first_zero_d;
        kvs_pkg::KeyState:     rec_c.charge_state = tag;
        kvs_pkg::KeyPercent:   rec_c.charge_percent =
                                 (acc_d > kvs_pkg::PctMax) ? kvs_pkg::PctMax[7:0] : acc_d[7:0];
        kvs_pkg::KeyDesign:    rec_c.design_capacity = acc_d;
        kvs_pkg::KeyRemaining: rec_c.remaining_capacity = acc_d;
        kvs_pkg::KeyRate:      rec_c.present_rate = acc_d;
        default:               rec_c = rec_q;
      endcase
    end
    rec_d = rec_c;

    // Final byte: the record leaves and the parser starts over
    if (item_i.final_byte) begin
      phase_d      = PhSep;
      key_pos_d    = '0;
      key_cand_d   = '1;
      nonempty_d   = 1'b0;
      first_zero_d = 1'b0;
      acc_d        = '0;
      stopped_d    = 1'b0;
      tag_pos_d    = '0;
      tag_cand_d   = '1;
      rec_d        = kvs_pkg::RecReset;
    end
  end

  assign emit_o = step_i && item_i.final_byte;
  assign rec_o  = rec_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSep;
      key_pos_q    <= '0;
      key_cand_q   <= '1;
      nonempty_q   <= 1'b0;
      first_zero_q <= 1'b0;
      acc_q        <= '0;
      stopped_q    <= 1'b0;
      tag_pos_q    <= '0;
      tag_cand_q   <= '1;
      rec_q        <= kvs_pkg::RecReset;
    end else if (step_i) begin
      phase_q      <= phase_d;
      key_pos_q    <= key_pos_d;
      key_cand_q   <= key_cand_d;
      nonempty_q   <= nonempty_d;
      first_zero_q <= first_zero_d;
      acc_q        <= acc_d;
      stopped_q    <= stopped_d;
      tag_pos_q    <= tag_pos_d;
      tag_cand_q   <= tag_cand_d;
      rec_q        <= rec_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kvs_out_reg.sv =====
// Result register: holds one finished status record until the receiver takes it.
`default_nettype none

module kvs_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire kvs_pkg::kvs_rec_t rec_i,
  output logic                   free_o,
  kvs_out_if.source              out_o
);

  logic              valid_q;
  kvs_pkg::kvs_rec_t rec_q;

  assign free_o = !valid_q || out_o.ready;

  assign out_o.valid              = valid_q;
  assign out_o.recognized         = rec_q.recognized;
  assign out_o.battery_present    = rec_q.battery_present;
  assign out_o.charge_state       = rec_q.charge_state;
  assign out_o.charge_percent     = rec_q.charge_percent;
  assign out_o.design_capacity    = rec_q.design_capacity;
  assign out_o.remaining_capacity = rec_q.remaining_capacity;
  assign out_o.present_rate       = rec_q.present_rate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/key_value_status_string_parser.sv =====
// Battery status string parser: text bytes in, one status record per string out.
//
// in_i carries one character per transfer with final_byte on the last one of a
// string. out_o carries one record per string, transferred after its final byte.
// Each byte is registered, then parsed; a record is loaded into the result register
// when its final byte is parsed, shows on out_o from there and can transfer at the
// following edge. Throughput is one byte per cycle while no final byte waits on
// the result register, set by the single parse stage: the decimal step (multiply
// by ten, add, compare) and keyword compares are combinational.
// When out_o is stalled with a record waiting, non-final bytes keep flowing;
// a final byte holds in the input register until the result register frees,
// and in_i.ready drops behind it.
// Reset clears both registers and returns the parser to its between-tokens
// state with default record values: present 1, state unknown, percent 255,
// capacities and rate zero. No memory clearing pass is needed.
`default_nettype none

module key_value_status_string_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kvs_in_if.sink    in_i,
  kvs_out_if.source out_o
);

  logic               item_valid;
  kvs_pkg::kvs_item_t item;
  logic               out_free;
  logic               step;
  logic               emit;
  kvs_pkg::kvs_rec_t  rec;

  // Advance unless a final byte would overwrite an untaken record
  assign step = item_valid && (!item.final_byte || out_free);

  kvs_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .take_i       (step),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  kvs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .emit_o (emit),
    .rec_o  (rec)
  );

  kvs_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (emit),
    .rec_i  (rec),
    .free_o (out_free),
    .out_o  (out_o)
  );

`ifndef ASSERT_OFF
  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("record emitted while result register occupied");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_o.valid)
    else $error("emitted record not presented");

  a_percent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.charge_percent <= kvs_pkg::PctMax[7:0] ||
                     out_o.charge_percent == kvs_pkg::PctUnknown))
    else $error("charge percent out of range");

  a_unrecognized_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.recognized) |->
      (out_o.battery_present && out_o.charge_state == kvs_pkg::StateUnknown &&
       out_o.charge_percent == kvs_pkg::PctUnknown && out_o.design_capacity == 32'd0 &&
       out_o.remaining_capacity == 32'd0 && out_o.present_rate == 32'd0))
    else $error("record without known key carries non-default values");
`endif

endmodule

`default_nettype wire
